### src/kas_pkg.sv
// shared types, constants and helpers for the keyframe animation sequencer
`default_nettype none

package kas_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);

  localparam int OP_W    = 2;
  localparam int INDEX_W = 8;
  localparam int FRAME_W = 10;
  localparam int TIME_W  = 16;
  localparam int ACCUM_W = TIME_W + 1;
  localparam int BLEND_W = 17;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  localparam int DIV_STEPS = BLEND_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << TIME_W;

  localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_CHANGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] last;
    logic [TIME_W-1:0]  ftime;
  } anim_entry_t;

  localparam int ENTRY_W = $bits(anim_entry_t);

  function automatic slot_t slot_after(input slot_t s);
    slot_t r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/kas_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module kas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/keyframe_animation_sequencer.sv
// keyframe animation sequencer top level: queue control, frame loop and serial divider
// append, change, unused code or advance on an empty queue go from idle to output
// advance: frame loop, one frame step per cycle aside from the read state that switches animations,
//   then the bit-serial blend divider, skipped when the frame time is zero
// throughput: one transaction in flight; the next is taken once the result is registered,
//   so a stalled result receiver holds off the next transaction
// reset: synchronous, active low; clears cursors, frame state, timer and output valid;
//   queue contents stay undefined until written, no clearing pass
`default_nettype none

module keyframe_animation_sequencer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [7:0] anim_index, [17:8] anim_first_frame, [27:18] anim_last_frame,
  // [43:28] anim_frame_time, [59:44] elapsed_ms, [63:60] zero
  input  wire logic [kas_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  wire logic [kas_pkg::OP_W-1:0]       in_tuser,
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [9:0] frame, [19:10] old_frame, [36:20] blend, [44:37] current_anim, [47:45] zero
  output logic      [kas_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] active
  output logic                                out_tuser
);

  import kas_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOP = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // input field split
  logic [OP_W-1:0]    in_op;
  logic [INDEX_W-1:0] in_idx;
  logic [FRAME_W-1:0] in_first;
  logic [FRAME_W-1:0] in_last;
  logic [TIME_W-1:0]  in_ftime;
  logic [TIME_W-1:0]  in_ms;
  anim_entry_t        in_entry;

  assign in_op    = in_tuser;
  assign in_idx   = in_tdata[7:0];
  assign in_first = in_tdata[17:8];
  assign in_last  = in_tdata[27:18];
  assign in_ftime = in_tdata[43:28];
  assign in_ms    = in_tdata[59:44];
  assign in_entry = '{idx: in_idx, first: in_first, last: in_last, ftime: in_ftime};

  // control state
  logic [2:0]         state_r, state_nxt;
  slot_t              cur_slot_r, cur_slot_nxt;
  slot_t              add_slot_r, add_slot_nxt;
  logic [FRAME_W-1:0] cur_frame_r, cur_frame_nxt;
  logic [FRAME_W-1:0] prev_frame_r, prev_frame_nxt;
  logic [TIME_W-1:0]  ftime_r, ftime_nxt;
  logic [ACCUM_W-1:0] accum_r, accum_nxt;
  logic               pending_r, pending_nxt;
  logic [BLEND_W-1:0] blend_r, blend_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload state: copy of the playing slot, divider, output register
  anim_entry_t          cur_ent_r, cur_ent_nxt;
  logic [BLEND_W-1:0]   rem_r, rem_nxt;
  logic [BLEND_W-1:0]   quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                 out_act_r, out_act_nxt;

  // queue storage
  logic        wr_en;
  slot_t       wr_addr;
  logic        rd_en;
  slot_t       rd_addr;
  logic [ENTRY_W-1:0] rd_raw;
  anim_entry_t rd_ent;

  kas_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_ent = anim_entry_t'(rd_raw);

  // queue is empty when both cursors meet
  logic queue_empty;
  assign queue_empty = (cur_slot_r == add_slot_r);

  // restoring divider step: first step tests accum itself, later steps shift
  logic [BLEND_W:0]   trial;
  logic               trial_ge;
  logic [BLEND_W-1:0] quo_shift;

  assign trial     = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign trial_ge  = (trial >= {2'b00, ftime_r});
  assign quo_shift = {quo_r[BLEND_W-2:0], trial_ge};

  // output word as it would be registered now
  logic [INDEX_W-1:0] anim_shown;
  assign anim_shown = queue_empty ? '0 : cur_ent_r.idx;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_act_r;

  always_comb begin
    state_nxt      = state_r;
    cur_slot_nxt   = cur_slot_r;
    add_slot_nxt   = add_slot_r;
    cur_frame_nxt  = cur_frame_r;
    prev_frame_nxt = prev_frame_r;
    ftime_nxt      = ftime_r;
    accum_nxt      = accum_r;
    pending_nxt    = pending_r;
    blend_nxt      = blend_r;
    out_valid_nxt  = out_valid_r;
    cur_ent_nxt    = cur_ent_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    out_data_nxt   = out_data_r;
    out_act_nxt    = out_act_r;
    wr_en          = 1'b0;
    wr_addr        = add_slot_r;
    rd_en          = 1'b0;
    rd_addr        = slot_after(cur_slot_r);

    // downstream takes the pending result
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            OP_APPEND, OP_CHANGE: begin
              wr_en = 1'b1;
              if (queue_empty) begin
                // load the animation straight into the player
                prev_frame_nxt = in_first;
                cur_frame_nxt  = (in_last > in_first) ? in_first + FRAME_W'(1) : in_first;
                blend_nxt      = (in_op == OP_APPEND) ? '0 : BLEND_ONE;
                ftime_nxt      = in_ftime;
                accum_nxt      = '0;
                pending_nxt    = 1'b1;
                cur_ent_nxt    = in_entry;
                wr_addr        = add_slot_r;
              end else if (in_op == OP_CHANGE) begin
                // drop the queued tail, keep the playing slot
                wr_addr = slot_after(cur_slot_r);
                if (in_ftime < ftime_r) begin
                  ftime_nxt = in_ftime;
                end
                if (in_idx != cur_ent_r.idx) begin
                  pending_nxt = 1'b1;
                end
              end else begin
                wr_addr = add_slot_r;
              end
              add_slot_nxt = slot_after(wr_addr);
              state_nxt    = S_OUT;
            end
            OP_ADVANCE: begin
              if (queue_empty) begin
                state_nxt = S_OUT;
              end else begin
                accum_nxt = accum_r + ACCUM_W'(in_ms);
                state_nxt = S_LOOP;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_LOOP: begin
        // one frame step per cycle, read-state switches aside, while timer > frame time
        if (accum_r > {1'b0, ftime_r}) begin
          accum_nxt = accum_r - {1'b0, ftime_r};
          if (pending_r || (cur_frame_r >= cur_ent_r.last)) begin
            if (slot_after(cur_slot_r) != add_slot_r) begin
              // fetch the next queued animation
              rd_en     = 1'b1;
              state_nxt = S_READ;
            end else begin
              // last animation loops from its first frame
              accum_nxt      = '0;
              ftime_nxt      = cur_ent_r.ftime;
              prev_frame_nxt = cur_frame_r;
              cur_frame_nxt  = cur_ent_r.first;
              pending_nxt    = 1'b0;
            end
          end else begin
            ftime_nxt      = cur_ent_r.ftime;
            prev_frame_nxt = cur_frame_r;
            cur_frame_nxt  = cur_frame_r + FRAME_W'(1);
          end
        end else if (ftime_r == '0) begin
          blend_nxt = BLEND_ONE;
          state_nxt = S_OUT;
        end else begin
          rem_nxt   = accum_r;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end

      S_READ: begin
        cur_slot_nxt   = slot_after(cur_slot_r);
        cur_ent_nxt    = rd_ent;
        accum_nxt      = '0;
        ftime_nxt      = rd_ent.ftime;
        prev_frame_nxt = cur_frame_r;
        cur_frame_nxt  = rd_ent.first;
        pending_nxt    = 1'b0;
        state_nxt      = S_LOOP;
      end

      S_DIV: begin
        // one quotient bit of accum * 65536 / frame time per cycle
        rem_nxt = trial_ge ? BLEND_W'(trial - {2'b00, ftime_r}) : trial[BLEND_W-1:0];
        quo_nxt = quo_shift;
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          blend_nxt = BLEND_ONE - quo_shift;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        // register the result once the output stage is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, anim_shown, blend_r, prev_frame_r, cur_frame_r};
          out_act_nxt   = !queue_empty;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_slot_r   <= '0;
      add_slot_r   <= '0;
      cur_frame_r  <= '0;
      prev_frame_r <= '0;
      ftime_r      <= '0;
      accum_r      <= '0;
      pending_r    <= 1'b0;
      blend_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_slot_r   <= cur_slot_nxt;
      add_slot_r   <= add_slot_nxt;
      cur_frame_r  <= cur_frame_nxt;
      prev_frame_r <= prev_frame_nxt;
      ftime_r      <= ftime_nxt;
      accum_r      <= accum_nxt;
      pending_r    <= pending_nxt;
      blend_r      <= blend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_ent_r  <= cur_ent_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    out_act_r  <= out_act_nxt;
  end

endmodule

`default_nettype wire
